### rtl/transition_record_parser_defines.svh
// assertion macros shared by the transition record parser rtl
`ifndef TRANSITION_RECORD_PARSER_DEFINES_SVH
`define TRANSITION_RECORD_PARSER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define TRP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define TRP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/trp_pkg.sv
// shared types, constants and codes of the transition record parser
`default_nettype none

package trp_pkg;

  // record layout
  localparam int HEADER_BYTES = 24;
  localparam int MAGIC_BYTES  = 8;
  localparam int MAGIC_IDX_W  = $clog2(MAGIC_BYTES);
  localparam int INDEX_END    = 12;
  localparam int AMOUNT_END   = 20;
  localparam int DLEN_END     = 22;

  // field widths
  localparam int POS_W        = 18;
  localparam int INDEX_W      = 32;
  localparam int AMOUNT_W     = 64;
  localparam int MAX_AMOUNT_W = 63;
  localparam int LEN_W        = 16;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [MAX_AMOUNT_W-1:0] MAX_AMOUNT_RST = {MAX_AMOUNT_W{1'b1}};
  localparam logic [LEN_W-1:0]        MAX_ELEM_RST   = 16'd520;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // magic "QQEUTXO1"
  localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{
    8'h51, 8'h51, 8'h45, 8'h55, 8'h54, 8'h58, 8'h4F, 8'h31
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_AMOUNT       = 8'd0,
    REG_MAX_ELEMENT_SIZE = 8'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PART_NONE      = 2'd0,
    PART_DATUM     = 2'd1,
    PART_VALIDATOR = 2'd2,
    PART_EXCESS    = 2'd3
  } part_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_MAGIC     = 3'd1,
    ST_TRUNCATED    = 3'd2,
    ST_AMOUNT_RANGE = 3'd3,
    ST_TOO_LARGE    = 3'd4,
    ST_LEN_MISMATCH = 3'd5
  } status_t;

  // classified byte as handed from front to back
  typedef struct packed {
    part_t                part;
    logic [7:0]           payload_byte;
    logic                 record_end;
    logic                 no_magic;
    logic                 truncated;
    logic                 too_large;
    logic                 len_mismatch;
    logic [INDEX_W-1:0]   target_index;
    logic [AMOUNT_W-1:0]  amount;
    logic [LEN_W-1:0]     datum_length;
    logic [LEN_W-1:0]     validator_length;
  } item_t;

  // registered result
  typedef struct packed {
    part_t                part;
    logic [7:0]           payload_byte;
    logic                 record_end;
    status_t              status;
    logic [INDEX_W-1:0]   target_index;
    logic [AMOUNT_W-1:0]  amount;
    logic [LEN_W-1:0]     datum_length;
    logic [LEN_W-1:0]     validator_length;
  } result_t;

endpackage

`default_nettype wire

### rtl/trp_channels.sv
// valid/ready channel interfaces: record bytes, results, configuration writes
`default_nettype none

interface trp_in_if;
  import trp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface trp_out_if;
  import trp_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          part;
  logic [7:0]          payload_byte;
  logic                record_end;
  logic [2:0]          status;
  logic [INDEX_W-1:0]  target_index;
  logic [AMOUNT_W-1:0] amount;
  logic [LEN_W-1:0]    datum_length;
  logic [LEN_W-1:0]    validator_length;
  modport source (output valid, part, payload_byte, record_end, status, target_index,
                  amount, datum_length, validator_length, input ready);
  modport sink   (input valid, part, payload_byte, record_end, status, target_index,
                  amount, datum_length, validator_length, output ready);
endinterface

interface trp_cfg_if;
  import trp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

### rtl/trp_front.sv
// front end: byte counter, magic check, header assembly and byte tagging
`default_nettype none

module trp_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  trp_in_if.sink                              in_ch,
  input  wire logic [trp_pkg::LEN_W-1:0]      max_element_size,
  output logic                                wr_valid,
  input  wire logic                           wr_ready,
  output trp_pkg::item_t                      wr_item
);
  import trp_pkg::*;

  logic                accept;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                magic_ok_r, magic_ok_nxt;
  logic [INDEX_W-1:0]  idx_r, idx_nxt;
  logic [AMOUNT_W-1:0] amt_r, amt_nxt;
  logic [LEN_W-1:0]    dlen_r, dlen_nxt;
  logic [LEN_W-1:0]    vlen_r, vlen_nxt;
  logic [LEN_W-1:0]    vlen_fin;
  logic [POS_W-1:0]    datum_end;
  logic [POS_W-1:0]    payload_end;
  logic [POS_W:0]      total;

  // handshake: a request enters whenever the queue has room
  assign in_ch.ready = wr_ready;
  assign wr_valid    = in_ch.valid;
  assign accept      = in_ch.valid & in_ch.ready;

  // payload boundaries measured from the start of the record
  assign datum_end   = POS_W'(HEADER_BYTES) + POS_W'(dlen_r);
  assign payload_end = datum_end + POS_W'(vlen_r);
  assign total       = {1'b0, pos_r} + 1'b1;

  // header assembly, tagging and verdict flags
  always_comb begin
    pos_nxt      = pos_r;
    magic_ok_nxt = magic_ok_r;
    idx_nxt      = idx_r;
    amt_nxt      = amt_r;
    dlen_nxt     = dlen_r;
    vlen_nxt     = vlen_r;

    wr_item              = '0;
    wr_item.part         = PART_NONE;
    wr_item.payload_byte = '0;

    if (pos_r < POS_W'(MAGIC_BYTES)) begin
      if (in_ch.data_byte != MAGIC[pos_r[MAGIC_IDX_W-1:0]]) begin
        magic_ok_nxt = 1'b0;
      end
    end else if (pos_r < POS_W'(INDEX_END)) begin
      idx_nxt = {in_ch.data_byte, idx_r[INDEX_W-1:8]};
    end else if (pos_r < POS_W'(AMOUNT_END)) begin
      amt_nxt = {in_ch.data_byte, amt_r[AMOUNT_W-1:8]};
    end else if (pos_r < POS_W'(DLEN_END)) begin
      dlen_nxt = {in_ch.data_byte, dlen_r[LEN_W-1:8]};
    end else if (pos_r < POS_W'(HEADER_BYTES)) begin
      vlen_nxt = {in_ch.data_byte, vlen_r[LEN_W-1:8]};
    end else begin
      wr_item.payload_byte = in_ch.data_byte;
      if (pos_r < datum_end) begin
        wr_item.part = PART_DATUM;
      end else if (pos_r < payload_end) begin
        wr_item.part = PART_VALIDATOR;
      end else begin
        wr_item.part = PART_EXCESS;
      end
    end

    // validator length including this byte, the last header byte may be in hand
    vlen_fin = vlen_nxt;

    // verdict inputs, only meaningful on the last byte
    wr_item.record_end       = in_ch.last_byte;
    wr_item.no_magic         = (pos_r < POS_W'(MAGIC_BYTES - 1)) | ~magic_ok_nxt;
    wr_item.truncated        = pos_r < POS_W'(HEADER_BYTES - 1);
    wr_item.too_large        = (dlen_r > max_element_size) | (vlen_fin > max_element_size);
    wr_item.len_mismatch     = total != {1'b0, datum_end + POS_W'(vlen_fin)};
    wr_item.target_index     = idx_r;
    wr_item.amount           = amt_r;
    wr_item.datum_length     = dlen_r;
    wr_item.validator_length = vlen_fin;

    // counter: restart after the last byte, saturate otherwise
    if (in_ch.last_byte) begin
      pos_nxt      = '0;
      magic_ok_nxt = 1'b1;
      idx_nxt      = '0;
      amt_nxt      = '0;
      dlen_nxt     = '0;
      vlen_nxt     = '0;
    end else if (pos_r != {POS_W{1'b1}}) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      magic_ok_r <= 1'b1;
    end else if (accept) begin
      pos_r      <= pos_nxt;
      magic_ok_r <= magic_ok_nxt;
    end
  end

  // header shift registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      amt_r  <= '0;
      dlen_r <= '0;
      vlen_r <= '0;
    end else if (accept) begin
      idx_r  <= idx_nxt;
      amt_r  <= amt_nxt;
      dlen_r <= dlen_nxt;
      vlen_r <= vlen_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/trp_queue.sv
// short first-in first-out queue of classified bytes between front and back
`default_nettype none
`include "transition_record_parser_defines.svh"

module trp_queue #(
  parameter int DEPTH = trp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire trp_pkg::item_t wr_item,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output trp_pkg::item_t      rd_item
);
  import trp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;
  assign rd_item  = slot_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  `TRP_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "queue fill beyond depth")
  `TRP_ASSERT_NEXT(a_push_grows, push && !pop, count_r == $past(count_r) + 1'b1, "push lost")
  `TRP_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_r == $past(count_r) - 1'b1, "pop lost")

endmodule

`default_nettype wire

### rtl/trp_back.sv
// back end: verdict priority and the registered result stage
`default_nettype none
`include "transition_record_parser_defines.svh"

module trp_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                rd_valid,
  output logic                                     rd_ready,
  input  wire trp_pkg::item_t                      rd_item,
  input  wire logic [trp_pkg::MAX_AMOUNT_W-1:0]    max_amount,
  trp_out_if.source                                out_ch
);
  import trp_pkg::*;

  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    pop;
  logic    amount_big;
  logic    keep_fields;

  // result stage takes a new request whenever it is empty or being drained
  assign rd_ready   = ~out_valid_r | out_ch.ready;
  assign pop        = rd_valid & rd_ready;
  assign amount_big = rd_item.amount > {1'b0, max_amount};

  // verdict in the order of the checks
  always_comb begin
    res_nxt              = '0;
    res_nxt.part         = rd_item.part;
    res_nxt.payload_byte = rd_item.payload_byte;
    res_nxt.record_end   = rd_item.record_end;
    res_nxt.status       = ST_OK;
    if (rd_item.record_end) begin
      if (rd_item.no_magic) begin
        res_nxt.status = ST_NO_MAGIC;
      end else if (rd_item.truncated) begin
        res_nxt.status = ST_TRUNCATED;
      end else if (amount_big) begin
        res_nxt.status = ST_AMOUNT_RANGE;
      end else if (rd_item.too_large) begin
        res_nxt.status = ST_TOO_LARGE;
      end else if (rd_item.len_mismatch) begin
        res_nxt.status = ST_LEN_MISMATCH;
      end else begin
        res_nxt.status = ST_OK;
      end
    end
    keep_fields = rd_item.record_end & ~rd_item.no_magic & ~rd_item.truncated;
    if (keep_fields) begin
      res_nxt.target_index     = rd_item.target_index;
      res_nxt.amount           = rd_item.amount;
      res_nxt.datum_length     = rd_item.datum_length;
      res_nxt.validator_length = rd_item.validator_length;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.part             = res_r.part;
  assign out_ch.payload_byte     = res_r.payload_byte;
  assign out_ch.record_end       = res_r.record_end;
  assign out_ch.status           = res_r.status;
  assign out_ch.target_index     = res_r.target_index;
  assign out_ch.amount           = res_r.amount;
  assign out_ch.datum_length     = res_r.datum_length;
  assign out_ch.validator_length = res_r.validator_length;

  `TRP_ASSERT_NEXT(a_fill_empty_stage, rd_valid && !out_valid_r, out_valid_r, "stage not filled")
  `TRP_ASSERT_IMPL(a_mid_record_ok, out_valid_r && !res_r.record_end,
                   res_r.status == ST_OK, "verdict off record end")
  `TRP_ASSERT_IMPL(a_early_fields_zero,
                   out_valid_r && (res_r.status == ST_NO_MAGIC || res_r.status == ST_TRUNCATED),
                   res_r.amount == '0 && res_r.target_index == '0, "header fields leak")

endmodule

`default_nettype wire

### rtl/transition_record_parser.sv
// Transition record parser top level: configuration registers, front, queue, back.
//
// in_ch takes one record byte per request, with last_byte set on the final byte.
// out_ch gives one result per input byte, in order: header bytes come out as
// part none, payload bytes tagged datum, validator or excess, and the final
// byte also carries record_end, the status and the decoded header fields.
// Payload results precede the verdict; drop them unless the status is ok.
// cfg_ch writes max_amount (index 0) or max_element_size (index 1) and is
// always ready; other indexes are ignored. Write only while the block is idle.
// A byte accepted on in_ch goes into the queue, then the result register, which
// offers it on out_ch. Throughput: one byte per cycle while out_ch is ready, set
// by the front step (counter and shift registers) and the result register.
// A stalled receiver holds the result register; the queue between front and
// back absorbs QUEUE_DEPTH further bytes before in_ch.ready drops.
// Reset (rst_n low, synchronous) empties the queue and result stage, restarts
// the byte counter and restores the register defaults.
`default_nettype none

module transition_record_parser #(
  parameter int QUEUE_DEPTH = trp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  trp_in_if.sink     in_ch,
  trp_out_if.source  out_ch,
  trp_cfg_if.sink    cfg_ch
);
  import trp_pkg::*;

  logic [MAX_AMOUNT_W-1:0] max_amount_r;
  logic [LEN_W-1:0]        max_elem_r;
  logic                    q_wr_valid;
  logic                    q_wr_ready;
  item_t                   q_wr_item;
  logic                    q_rd_valid;
  logic                    q_rd_ready;
  item_t                   q_rd_item;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_amount_r <= MAX_AMOUNT_RST;
      max_elem_r   <= MAX_ELEM_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_MAX_AMOUNT:       max_amount_r <= cfg_ch.wdata[MAX_AMOUNT_W-1:0];
        REG_MAX_ELEMENT_SIZE: max_elem_r   <= cfg_ch.wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // byte classification
  trp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .max_element_size (max_elem_r),
    .wr_valid         (q_wr_valid),
    .wr_ready         (q_wr_ready),
    .wr_item          (q_wr_item)
  );

  // decoupling queue
  trp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (q_wr_item),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_item  (q_rd_item)
  );

  // verdict and result stage
  trp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_valid   (q_rd_valid),
    .rd_ready   (q_rd_ready),
    .rd_item    (q_rd_item),
    .max_amount (max_amount_r),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench of the transition record parser: record byte stream in, per-byte results
`timescale 1ns / 100ps

module tb;
  import trp_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 9;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;

  // record layout
  localparam int MAGIC_LEN = 8;
  localparam int IDX_END   = 12;
  localparam int AMT_END   = 20;
  localparam int DLEN_END  = 22;
  localparam int HDR_LEN   = 24;
  localparam int NO_FAULT  = -1;

  localparam logic [17:0] POS_LAST   = 18'h3FFFF;
  localparam logic [63:0] MAGIC_WORD = "QQEUTXO1";
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;

  typedef enum logic [1:0] {TX_STREAM, TX_BURSTY} tx_mode_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_LONG_HOLD} rx_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rec_byte_t;

  logic clk;
  logic rst_n;

  trp_in_if  in_ch ();
  trp_out_if out_ch ();
  trp_cfg_if cfg_ch ();

  transition_record_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rec_byte_t record_bytes_q[$];
  result_t   byte_results_q[$];

  // parser state as the block should hold it
  logic [17:0]             rec_pos;
  logic                    magic_ok;
  logic [INDEX_W-1:0]      index_acc;
  logic [AMOUNT_W-1:0]     amount_acc;
  logic [LEN_W-1:0]        dlen_acc;
  logic [LEN_W-1:0]        vlen_acc;
  logic [MAX_AMOUNT_W-1:0] lim_amount;
  logic [LEN_W-1:0]        lim_elem;

  int       mismatch_count = 0;
  int       idle_cycles = 0;
  int       bytes_made = 0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       rx_tick = 0;
  int       hold_left = 0;
  logic     byte_taken = 1'b0;
  tx_mode_t tx_mode = TX_BURSTY;
  rx_mode_t rx_mode = RX_RANDOM;
  rx_mode_t rx_prev = RX_RANDOM;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void clear_record_state();
    rec_pos    = '0;
    magic_ok   = 1'b1;
    index_acc  = '0;
    amount_acc = '0;
    dlen_acc   = '0;
    vlen_acc   = '0;
  endfunction

  // classify one record byte and, on the final byte, work out the verdict
  function automatic result_t parse_record_byte(logic [7:0] b, logic last);
    result_t r;
    int pos;
    int off;
    int total;
    r = '0;
    pos = int'(rec_pos);
    if (pos < MAGIC_LEN) begin
      if (b != MAGIC_WORD[63 - 8*pos -: 8]) magic_ok = 1'b0;
    end else if (pos < IDX_END) begin
      index_acc = {b, index_acc[INDEX_W-1:8]};
    end else if (pos < AMT_END) begin
      amount_acc = {b, amount_acc[AMOUNT_W-1:8]};
    end else if (pos < DLEN_END) begin
      dlen_acc = {b, dlen_acc[LEN_W-1:8]};
    end else if (pos < HDR_LEN) begin
      vlen_acc = {b, vlen_acc[LEN_W-1:8]};
    end else begin
      off = pos - HDR_LEN;
      if (off < int'(dlen_acc)) r.part = PART_DATUM;
      else if (off < int'(dlen_acc) + int'(vlen_acc)) r.part = PART_VALIDATOR;
      else r.part = PART_EXCESS;
      r.payload_byte = b;
    end

    if (last) begin
      total = pos + 1;
      r.record_end = 1'b1;
      if (total < MAGIC_LEN || !magic_ok) begin
        r.status = ST_NO_MAGIC;
      end else if (total < HDR_LEN) begin
        r.status = ST_TRUNCATED;
      end else begin
        if (amount_acc > {1'b0, lim_amount}) r.status = ST_AMOUNT_RANGE;
        else if (dlen_acc > lim_elem || vlen_acc > lim_elem) r.status = ST_TOO_LARGE;
        else if (total != HDR_LEN + int'(dlen_acc) + int'(vlen_acc)) r.status = ST_LEN_MISMATCH;
        else r.status = ST_OK;
        r.target_index     = index_acc;
        r.amount           = amount_acc;
        r.datum_length     = dlen_acc;
        r.validator_length = vlen_acc;
      end
      clear_record_state();
    end else if (rec_pos != POS_LAST) begin
      rec_pos = rec_pos + 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] seen_v);
    if (want_v !== seen_v) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want_v, seen_v);
    end
  endtask

  // monitor: register writes, result check, prediction of accepted bytes
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      lim_amount = '1;
      lim_elem   = 16'd520;
      clear_record_state();
      byte_taken <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MAX_AMOUNT:       lim_amount = cfg_ch.wdata[MAX_AMOUNT_W-1:0];
          REG_MAX_ELEMENT_SIZE: lim_elem = cfg_ch.wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (byte_results_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected no result, got part %0h status %0h end %0b",
                   $time, out_ch.part, out_ch.status, out_ch.record_end);
        end else begin
          want = byte_results_q.pop_front();
          check_field("part", 64'(want.part), 64'(out_ch.part));
          check_field("payload_byte", 64'(want.payload_byte), 64'(out_ch.payload_byte));
          check_field("record_end", 64'(want.record_end), 64'(out_ch.record_end));
          check_field("status", 64'(want.status), 64'(out_ch.status));
          check_field("target_index", 64'(want.target_index), 64'(out_ch.target_index));
          check_field("amount", want.amount, out_ch.amount);
          check_field("datum_length", 64'(want.datum_length), 64'(out_ch.datum_length));
          check_field("validator_length", 64'(want.validator_length),
                      64'(out_ch.validator_length));
        end
      end
      if (in_ch.valid && in_ch.ready)
        byte_results_q.push_back(parse_record_byte(in_ch.data_byte, in_ch.last_byte));
      byte_taken <= in_ch.valid && in_ch.ready;
    end
  end

  // byte sender: in bursty mode, bursts of random length with random gaps; streaming otherwise
  always @(negedge clk) begin
    rec_byte_t next_b;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      if (tx_mode == TX_BURSTY && gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (record_bytes_q.size() != 0) begin
        next_b = record_bytes_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= next_b.data_byte;
        in_ch.last_byte <= next_b.last_byte;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: stall patterns, and a long hold-off when that mode is entered
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      rx_prev <= rx_mode;
      if (rx_mode == RX_LONG_HOLD && rx_prev != RX_LONG_HOLD) begin
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ch.ready <= ((rx_tick % 7) < 4);
          default:    out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // queue one record; bad_magic corrupts that magic byte, total_len cuts or extends it
  task automatic push_record(int bad_magic, logic [31:0] idx, logic [63:0] amt,
                             logic [15:0] dl, logic [15:0] vl, int total_len);
    rec_byte_t rb;
    logic [7:0] salt;
    int j;
    for (j = 0; j < total_len; j++) begin
      salt = (j == bad_magic) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (j < MAGIC_LEN) rb.data_byte = MAGIC_WORD[63 - 8*j -: 8] ^ salt;
      else if (j < IDX_END) rb.data_byte = idx[8*(j-MAGIC_LEN) +: 8];
      else if (j < AMT_END) rb.data_byte = amt[8*(j-IDX_END) +: 8];
      else if (j < DLEN_END) rb.data_byte = dl[8*(j-AMT_END) +: 8];
      else if (j < HDR_LEN) rb.data_byte = vl[8*(j-DLEN_END) +: 8];
      else rb.data_byte = 8'($urandom);
      rb.last_byte = (j == total_len - 1);
      record_bytes_q.push_back(rb);
    end
    bytes_made += total_len;
  endtask

  // mostly well-formed records, the rest broken in one way or another
  task automatic push_random_record();
    int kind;
    int total;
    int len_cap;
    int bad;
    logic [63:0] lim64;
    logic [63:0] amt;
    logic [15:0] dl;
    logic [15:0] vl;
    kind    = $urandom_range(0, 19);
    lim64   = {1'b0, lim_amount};
    len_cap = (lim_elem < 6) ? int'(lim_elem) : 6;
    dl      = 16'($urandom_range(0, len_cap));
    vl      = 16'($urandom_range(0, len_cap));
    bad     = NO_FAULT;
    case ($urandom_range(0, 2))
      0:       amt = lim64;
      1:       amt = {$urandom, $urandom} % (lim64 + 64'd1);
      default: amt = '0;
    endcase
    total = HDR_LEN + int'(dl) + int'(vl);
    case (kind)
      14: bad = $urandom_range(0, MAGIC_LEN - 1);
      15: total = $urandom_range(1, HDR_LEN - 1);
      16: total = total + ($urandom_range(0, 1) ? $urandom_range(1, 3) : -$urandom_range(1, 3));
      17: amt = lim64 + 64'd1 + ({$urandom, $urandom} % (~lim64));
      18: begin
        if (lim_elem != 16'hFFFF) begin
          if ($urandom_range(0, 1)) dl = lim_elem + 16'd1;
          else vl = lim_elem + 16'd1;
        end
        total = HDR_LEN + int'(dl) + int'(vl);
      end
      19: begin
        bad   = $urandom_range(0, 1) ? $urandom_range(0, MAGIC_LEN - 1) : NO_FAULT;
        amt   = {$urandom, $urandom};
        dl    = 16'($urandom);
        vl    = 16'($urandom);
        total = $urandom_range(1, 40);
      end
      default: ;
    endcase
    push_record(bad, $urandom, amt, dl, vl, total);
  endtask

  task automatic run_random(int nbytes);
    int goal;
    int chunk_end;
    goal = bytes_made + nbytes;
    while (bytes_made < goal) begin
      tx_mode   = tx_mode_t'($urandom_range(0, 1));
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      chunk_end = bytes_made + $urandom_range(60, 250);
      while (bytes_made < chunk_end) push_random_record();
      while (record_bytes_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (record_bytes_q.size() != 0 || in_ch.valid || byte_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int hold_goal;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.wdata    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed records under the reset limits
    push_record(NO_FAULT, '0, '0, '0, '0, 1);            // single byte, too short
    push_record(NO_FAULT, '0, '0, '0, '0, 7);            // magic cut short
    push_record(0, '0, '0, '0, '0, HDR_LEN);             // first magic byte wrong
    push_record(MAGIC_LEN - 1, '0, '0, '0, '0, HDR_LEN); // last magic byte wrong
    push_record(NO_FAULT, '0, '0, '0, '0, MAGIC_LEN);    // truncated right after magic
    push_record(NO_FAULT, '1, '0, '0, '0, HDR_LEN - 1);  // truncated one short of header
    push_record(NO_FAULT, '1, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, HDR_LEN);
    push_record(NO_FAULT, '0, 64'h8000_0000_0000_0000, '0, '0, HDR_LEN);
    // amount range wins over too large and length mismatch
    push_record(NO_FAULT, 32'h1234_5678, '1, 16'd600, '0, HDR_LEN);
    push_record(NO_FAULT, $urandom, 64'd1, 16'd520, 16'd0, HDR_LEN + 520);
    push_record(NO_FAULT, $urandom, 64'd2, 16'd521, '0, HDR_LEN + 2);
    // too large wins over length mismatch
    push_record(NO_FAULT, $urandom, 64'd3, '0, 16'd521, HDR_LEN);
    push_record(NO_FAULT, $urandom, 64'd4, 16'd3, 16'd2, HDR_LEN + 4);
    push_record(NO_FAULT, $urandom, 64'd5, 16'd3, 16'd2, HDR_LEN + 9);
    push_record(NO_FAULT, $urandom, 64'd6, '0, '0, HDR_LEN + 6);
    push_record(NO_FAULT, $urandom, 64'd7, '0, 16'd4, HDR_LEN + 4);
    push_record(NO_FAULT, $urandom, '0, 16'hFFFF, 16'hFFFF, HDR_LEN);
    wait_for_drain();

    // tightest limits
    write_reg(REG_MAX_AMOUNT, '0);
    write_reg(REG_MAX_ELEMENT_SIZE, '0);
    write_reg(REG_SPARE, '1);
    run_random(300);
    wait_for_drain();

    // random limits; start with a long receiver hold while bytes keep coming
    write_reg(REG_MAX_AMOUNT, {$urandom, $urandom});
    write_reg(REG_MAX_ELEMENT_SIZE, 64'($urandom_range(1, 10)));
    tx_mode = TX_STREAM;
    rx_mode = RX_LONG_HOLD;
    hold_goal = bytes_made + 300;
    while (bytes_made < hold_goal) push_random_record();
    while (record_bytes_q.size() != 0) @(posedge clk);
    run_random(350);
    wait_for_drain();

    // widest limits; lengths far beyond the reset limit
    write_reg(REG_MAX_AMOUNT, '1);
    write_reg(REG_MAX_ELEMENT_SIZE, 64'hFFFF);
    tx_mode = TX_STREAM;
    rx_mode = RX_ALWAYS;
    push_record(NO_FAULT, $urandom, 64'h7FFF_FFFF_FFFF_FFFF, 16'd3, 16'd1, HDR_LEN + 4);
    push_record(NO_FAULT, $urandom, 64'd9, 16'hFFFF, 16'hFFFF, HDR_LEN + 10);
    push_record(NO_FAULT, $urandom, 64'd10, 16'd2, 16'd3, HDR_LEN + 5);
    wait_for_drain();

    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
